### rtl/core/crpi_pkg.sv
// shared types and constants for the circle pair impulse response unit
// used by the front, queue, divider, back and top level modules
package crpi_pkg;

  localparam int FRAC_BITS = 8;
  localparam int RESTI_FRAC = 8;
  localparam int VEL_W = 24;
  localparam int DIF_W = VEL_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int SUM_W = PRD_W + 1;
  localparam int RS_W = 16;
  localparam int RS2_W = 2 * RS_W;
  localparam int INV_W = 17;
  localparam int MASS_W = 16;
  localparam int E_W = RESTI_FRAC + 2;
  localparam int NEG_W = 43;
  localparam int NC_W = E_W + NEG_W;
  localparam int DI_W = RS2_W + INV_W;
  localparam int NX_W = NC_W + RS_W;
  localparam int DA_W = DI_W + MASS_W;
  localparam int NUM_W = NX_W + 2 * FRAC_BITS;
  localparam int DEN_W = DA_W + RESTI_FRAC;
  localparam int QB = 41;
  localparam int MAG_W = QB;
  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (QB - 1);
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int IN_W = 264;
  localparam int OUT_W = 4 * VEL_W;
  localparam logic [8:0] RESTI_RESET = 9'd256;

  typedef struct packed {
    logic hit;
    logic sx;
    logic sy;
    logic [VEL_W-1:0] va_x;
    logic [VEL_W-1:0] va_y;
    logic [VEL_W-1:0] vb_x;
    logic [VEL_W-1:0] vb_y;
    logic [NX_W-1:0] nx;
    logic [NX_W-1:0] ny;
    logic [DA_W-1:0] da;
    logic [DA_W-1:0] db;
  } crpi_entry_t;

endpackage

### rtl/core/crpi_front.sv
// front part: accepts pairs, forms differences, overlap test and the products
// feeding the dividers; depends on crpi_pkg
module crpi_front import crpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [IN_W-1:0]    in_data,
  input  logic [8:0]         restitution,
  input  logic               en,
  output logic               push,
  output crpi_entry_t        entry
);

  logic [4:0] vld;

  // stage 1
  logic signed [DIF_W-1:0] dx, dy, wx, wy;
  logic [VEL_W-1:0] va_x1, va_y1, vb_x1, vb_y1;
  logic [RS_W-1:0] rs1;
  logic [INV_W-1:0] inv1;
  logic [MASS_W-1:0] ma1, mb1;
  // stage 2
  logic signed [PRD_W-1:0] pxx, pyy, sxx, syy;
  logic [RS2_W-1:0] rs2;
  logic signed [DIF_W-1:0] dx2, dy2;
  logic [VEL_W-1:0] va_x2, va_y2, vb_x2, vb_y2;
  logic [INV_W-1:0] inv2;
  logic [MASS_W-1:0] ma2, mb2;
  // stage 3
  logic hit3, sx3, sy3;
  logic [NEG_W-1:0] negdot;
  logic [RS2_W-1:0] d2_3;
  logic [RS_W-1:0] adx3, ady3;
  logic [VEL_W-1:0] va_x3, va_y3, vb_x3, vb_y3;
  logic [INV_W-1:0] inv3;
  logic [MASS_W-1:0] ma3, mb3;
  // stage 4
  logic hit4, sx4, sy4;
  logic [NC_W-1:0] nc;
  logic [DI_W-1:0] di;
  logic [RS_W-1:0] adx4, ady4;
  logic [VEL_W-1:0] va_x4, va_y4, vb_x4, vb_y4;
  logic [MASS_W-1:0] ma4, mb4;

  logic signed [SUM_W-1:0] dot, d2;
  logic [E_W-1:0] e1;
  logic signed [DIF_W-1:0] ndx, ndy;

  assign dot = SUM_W'(pxx) + SUM_W'(pyy);
  assign d2  = SUM_W'(sxx) + SUM_W'(syy);
  assign e1  = E_W'(restitution) + (E_W'(1) << RESTI_FRAC);
  assign ndx = -dx2;
  assign ndy = -dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DIF_W'(signed'(in_data[23:0])) - DIF_W'(signed'(in_data[71:48]));
      dy <= DIF_W'(signed'(in_data[47:24])) - DIF_W'(signed'(in_data[95:72]));
      wx <= DIF_W'(signed'(in_data[119:96])) - DIF_W'(signed'(in_data[167:144]));
      wy <= DIF_W'(signed'(in_data[143:120])) - DIF_W'(signed'(in_data[191:168]));
      va_x1 <= in_data[119:96];
      va_y1 <= in_data[143:120];
      vb_x1 <= in_data[167:144];
      vb_y1 <= in_data[191:168];
      rs1 <= in_data[207:192];
      // zero masses count as the smallest legal value
      inv1 <= (in_data[224:208] == '0) ? INV_W'(1) : in_data[224:208];
      ma1 <= (in_data[240:225] == '0) ? MASS_W'(1) : in_data[240:225];
      mb1 <= (in_data[256:241] == '0) ? MASS_W'(1) : in_data[256:241];

      pxx <= dx * wx;
      pyy <= dy * wy;
      sxx <= dx * dx;
      syy <= dy * dy;
      rs2 <= rs1 * rs1;
      dx2 <= dx;
      dy2 <= dy;
      va_x2 <= va_x1; va_y2 <= va_y1; vb_x2 <= vb_x1; vb_y2 <= vb_y1;
      inv2 <= inv1; ma2 <= ma1; mb2 <= mb1;

      hit3 <= dot[SUM_W-1] && (d2 <= SUM_W'(rs2));
      negdot <= NEG_W'(-dot);
      d2_3 <= RS2_W'(d2);
      sx3 <= dx2[DIF_W-1];
      sy3 <= dy2[DIF_W-1];
      adx3 <= dx2[DIF_W-1] ? RS_W'(ndx) : RS_W'(dx2);
      ady3 <= dy2[DIF_W-1] ? RS_W'(ndy) : RS_W'(dy2);
      va_x3 <= va_x2; va_y3 <= va_y2; vb_x3 <= vb_x2; vb_y3 <= vb_y2;
      inv3 <= inv2; ma3 <= ma2; mb3 <= mb2;

      hit4 <= hit3; sx4 <= sx3; sy4 <= sy3;
      nc <= e1 * negdot;
      di <= d2_3 * inv3;
      adx4 <= adx3; ady4 <= ady3;
      va_x4 <= va_x3; va_y4 <= va_y3; vb_x4 <= vb_x3; vb_y4 <= vb_y3;
      ma4 <= ma3; mb4 <= mb3;

      entry.hit <= hit4;
      entry.sx <= sx4;
      entry.sy <= sy4;
      entry.va_x <= va_x4;
      entry.va_y <= va_y4;
      entry.vb_x <= vb_x4;
      entry.vb_y <= vb_y4;
      entry.nx <= nc * adx4;
      entry.ny <= nc * ady4;
      entry.da <= di * ma4;
      entry.db <= di * mb4;
    end
  end

  assign push = en && vld[4];

endmodule

### rtl/core/crpi_queue.sv
// short queue between front and back parts
// depends on crpi_pkg
module crpi_queue import crpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  crpi_entry_t wr_entry,
  input  logic        pop,
  output crpi_entry_t rd_entry,
  output logic        full,
  output logic        empty
);

  crpi_entry_t mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0] count;

  assign full = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

### rtl/core/crpi_div.sv
// pipelined restoring divider, one quotient bit per stage, capped magnitude
// depends on crpi_pkg
module crpi_div import crpi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [MAG_W-1:0] mag
);

  localparam int CMP_W = DEN_W + QB;

  logic [NUM_W-1:0] rem_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_q [QB+1];
  logic             cap_q [QB+1];

  // quotient of 2^QB or more is capped right away
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= num;
      den_q[0] <= den;
      quo_q[0] <= '0;
      cap_q[0] <= CMP_W'(num) >= (CMP_W'(den) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int SH = QB - k;
    logic [CMP_W-1:0] trial;
    logic take;
    assign trial = CMP_W'(den_q[k-1]) << SH;
    assign take = CMP_W'(rem_q[k-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= {quo_q[k-1][QB-2:0], take};
        cap_q[k] <= cap_q[k-1];
      end
    end
    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? rem_q[k-1] - NUM_W'(trial) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign mag = (cap_q[QB] || (quo_q[QB] > MAG_CAP)) ? MAG_CAP : quo_q[QB];

endmodule

### rtl/core/crpi_back.sv
// back part: four dividers, velocity update with saturation, output register
// depends on crpi_pkg and crpi_div
module crpi_back import crpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  crpi_entry_t        q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_data,
  output logic [1:0]         out_user
);

  localparam int ACC_W = MAG_W + 2;

  typedef struct packed {
    logic hit;
    logic sx;
    logic sy;
    logic [VEL_W-1:0] va_x;
    logic [VEL_W-1:0] va_y;
    logic [VEL_W-1:0] vb_x;
    logic [VEL_W-1:0] vb_y;
  } bpay_t;

  logic en;
  logic [QB:0] vld;
  bpay_t pl [QB+1];
  logic [MAG_W-1:0] m_ax, m_ay, m_bx, m_by;
  logic signed [ACC_W-1:0] dlt_x, dlt_y, s_ax, s_ay, s_bx, s_by;
  logic [VEL_W-1:0] r_ax, r_ay, r_bx, r_by;
  logic c_ax, c_ay, c_bx, c_by;

  function automatic logic [VEL_W:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] vmax, vmin;
    vmax = ACC_W'((1 << (VEL_W - 1)) - 1);
    vmin = -ACC_W'(1 << (VEL_W - 1));
    if (v > vmax) sat = {1'b1, VEL_W'(vmax)};
    else if (v < vmin) sat = {1'b1, VEL_W'(vmin)};
    else sat = {1'b0, VEL_W'(v)};
  endfunction

  assign en = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  crpi_div u_div_ax (.clk(clk), .en(en), .num({q_entry.nx, (2*FRAC_BITS)'(0)}),
    .den({q_entry.da, RESTI_FRAC'(0)}), .mag(m_ax));
  crpi_div u_div_ay (.clk(clk), .en(en), .num({q_entry.ny, (2*FRAC_BITS)'(0)}),
    .den({q_entry.da, RESTI_FRAC'(0)}), .mag(m_ay));
  crpi_div u_div_bx (.clk(clk), .en(en), .num({q_entry.nx, (2*FRAC_BITS)'(0)}),
    .den({q_entry.db, RESTI_FRAC'(0)}), .mag(m_bx));
  crpi_div u_div_by (.clk(clk), .en(en), .num({q_entry.ny, (2*FRAC_BITS)'(0)}),
    .den({q_entry.db, RESTI_FRAC'(0)}), .mag(m_by));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl[0] <= '{hit: q_entry.hit, sx: q_entry.sx, sy: q_entry.sy,
                 va_x: q_entry.va_x, va_y: q_entry.va_y,
                 vb_x: q_entry.vb_x, vb_y: q_entry.vb_y};
      for (int k = 1; k <= QB; k++) pl[k] <= pl[k-1];
    end
  end

  // the shared direction sign: A gains the change, B loses it
  assign dlt_x = pl[QB].sx ? -ACC_W'(m_ax) : ACC_W'(m_ax);
  assign dlt_y = pl[QB].sy ? -ACC_W'(m_ay) : ACC_W'(m_ay);
  assign s_ax = ACC_W'(signed'(pl[QB].va_x)) + dlt_x;
  assign s_ay = ACC_W'(signed'(pl[QB].va_y)) + dlt_y;
  assign s_bx = ACC_W'(signed'(pl[QB].vb_x))
              - (pl[QB].sx ? -ACC_W'(m_bx) : ACC_W'(m_bx));
  assign s_by = ACC_W'(signed'(pl[QB].vb_y))
              - (pl[QB].sy ? -ACC_W'(m_by) : ACC_W'(m_by));
  assign {c_ax, r_ax} = sat(s_ax);
  assign {c_ay, r_ay} = sat(s_ay);
  assign {c_bx, r_bx} = sat(s_bx);
  assign {c_by, r_by} = sat(s_by);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pl[QB].hit) begin
        out_data <= {r_by, r_bx, r_ay, r_ax};
        out_user <= {c_ax || c_ay || c_bx || c_by, 1'b1};
      end else begin
        out_data <= {pl[QB].vb_y, pl[QB].vb_x, pl[QB].va_y, pl[QB].va_x};
        out_user <= 2'b00;
      end
    end
  end

endmodule

### rtl/core/circle_pair_impulse_response_unit.sv
// path: a pair passes the front part registers, the queue, the divider stages and the output register
// throughput: one pair per cycle unless stalled; dividers fully pipelined, one bit each stage
// a stalled output fills the four-entry queue before the input side stalls
// reset: synchronous, active high; clears all valid bits, the queue and sets restitution to 1.0
// top level: restitution register, front part, queue, back part; depends on crpi_pkg
module circle_pair_impulse_response_unit import crpi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [8:0]       cfg_wr_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
  // radius_sum, inv_mass_sum, mass_a, mass_b, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
  output logic [OUT_W-1:0] m_axis_tdata,
  // hit, clipped
  output logic [1:0]       m_axis_tuser
);

  logic [8:0] restitution;
  logic q_full, q_empty, push, pop;
  crpi_entry_t wr_entry, rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTI_RESET;
    end else if (cfg_wr_en) begin
      restitution <= cfg_wr_data;
    end
  end

  assign s_axis_tready = !q_full;

  crpi_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_data(s_axis_tdata),
    .restitution(restitution), .en(s_axis_tready), .push(push), .entry(wr_entry)
  );

  crpi_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_entry(wr_entry), .pop(pop),
    .rd_entry(rd_entry), .full(q_full), .empty(q_empty)
  );

  crpi_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_entry(rd_entry), .q_pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser)
  );

endmodule

### tb/circle_pair_impulse_response_checker.sv
`timescale 1ns / 1ps
// checker for the circle pair impulse response unit: watches the config port and both
// stream channels, predicts each pair's updated velocities and compares; uses crpi_pkg
module circle_pair_impulse_response_checker import crpi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [8:0]       cfg_wr_data,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  input  logic [1:0]       m_axis_tuser,
  output int               fail_count,
  output int               pending,
  output int               hit_count,
  output int               clip_count
);

  typedef struct packed {
    logic clipped;
    logic hit;
    logic [VEL_W-1:0] vb_y;
    logic [VEL_W-1:0] vb_x;
    logic [VEL_W-1:0] va_y;
    logic [VEL_W-1:0] va_x;
  } response_t;

  logic [8:0] restitution;
  response_t  expected_responses[$];

  // one velocity component after the impulse, exact quotient then cap then saturate
  function automatic logic [VEL_W-1:0] apply_impulse(input logic signed [VEL_W-1:0] v,
      input logic signed [DIF_W-1:0] dc, input bit add, input logic [159:0] num,
      input logic [159:0] den, input logic [15:0] mass, inout logic clip);
    logic [159:0] dabs;
    logic [159:0] q;
    logic signed [63:0] delta;
    logic signed [63:0] r;
    dabs = dc < 0 ? 160'(-dc) : 160'(dc);
    q = (num * dabs) / (den * 160'(mass == 0 ? 16'd1 : mass));
    if (q > (160'd1 << 40)) q = 160'd1 << 40;
    delta = 64'(q);
    if (dc < 0) delta = -delta;
    r = add ? 64'(v) + delta : 64'(v) - delta;
    if (r > 64'sd8388607) begin
      clip = 1'b1;
      r = 64'sd8388607;
    end
    if (r < -64'sd8388608) begin
      clip = 1'b1;
      r = -64'sd8388608;
    end
    return r[VEL_W-1:0];
  endfunction

  function automatic response_t resolve_pair(input logic [IN_W-1:0] d, input logic [8:0] e);
    logic signed [VEL_W-1:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    logic [15:0] rs, ma, mb;
    logic [16:0] inv;
    logic signed [DIF_W-1:0] dx, dy, wx, wy;
    logic signed [51:0] dot;
    logic [51:0] d2, negdot;
    logic [159:0] num, den;
    logic clip;
    response_t res;
    {pax, pay, pbx, pby} = {d[23:0], d[47:24], d[71:48], d[95:72]};
    {vax, vay, vbx, vby} = {d[119:96], d[143:120], d[167:144], d[191:168]};
    rs = d[207:192];
    inv = d[224:208];
    ma = d[240:225];
    mb = d[256:241];
    dx = DIF_W'(pax) - DIF_W'(pbx);
    dy = DIF_W'(pay) - DIF_W'(pby);
    wx = DIF_W'(vax) - DIF_W'(vbx);
    wy = DIF_W'(vay) - DIF_W'(vby);
    dot = dx * wx + dy * wy;
    d2 = dx * dx + dy * dy;
    clip = 1'b0;
    res = '{clipped: 1'b0, hit: 1'b0, vb_y: vby, vb_x: vbx, va_y: vay, va_x: vax};
    if (dot < 0 && d2 <= 52'(32'(rs) * 32'(rs))) begin
      negdot = -dot;
      num = ((160'(e) + 160'd256) * 160'(negdot)) << (2 * FRAC_BITS);
      den = 160'(d2) * 160'd256 * 160'(inv == 0 ? 17'd1 : inv);
      res.hit = 1'b1;
      res.va_x = apply_impulse(vax, dx, 1'b1, num, den, ma, clip);
      res.va_y = apply_impulse(vay, dy, 1'b1, num, den, ma, clip);
      res.vb_x = apply_impulse(vbx, dx, 1'b0, num, den, mb, clip);
      res.vb_y = apply_impulse(vby, dy, 1'b0, num, den, mb, clip);
      res.clipped = clip;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    response_t want, got;
    if (rst) begin
      restitution <= RESTI_RESET;
      expected_responses.delete();
      fail_count <= 0;
      hit_count <= 0;
      clip_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) restitution <= cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        expected_responses = {expected_responses, resolve_pair(s_axis_tdata, restitution)};
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata[95:72], m_axis_tdata[71:48],
               m_axis_tdata[47:24], m_axis_tdata[23:0]};
        if (expected_responses.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_responses.pop_front();
          hit_count <= hit_count + int'(want.hit);
          clip_count <= clip_count + int'(want.clipped);
          if (got != want) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: va_x %h/%h va_y %h/%h vb_x %h/%h vb_y %h/%h",
                       $realtime, want.va_x, got.va_x, want.va_y, got.va_y,
                       want.vb_x, got.vb_x, want.vb_y, got.vb_y);
              $display("  hit %b/%b clipped %b/%b (expected/actual)",
                       want.hit, got.hit, want.clipped, got.clipped);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_responses.size();
    end
  end

endmodule

### tb/circle_pair_impulse_response_unit_tb.sv
`timescale 1ns / 1ps
// top of the testbench: clock, reset, pair stimulus, restitution phases and verdict
// depends on crpi_pkg, the unit and circle_pair_impulse_response_checker
module circle_pair_impulse_response_unit_tb import crpi_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  int fail_count, pending, hit_count, clip_count;
  int cycles = 0;
  int pairs_sent = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  typedef struct {
    logic signed [23:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    logic [15:0] rs;
    logic [16:0] inv;
    logic [15:0] ma, mb;
  } pair_t;

  always #1 clk = ~clk;

  circle_pair_impulse_response_unit i_dut (.*);

  circle_pair_impulse_response_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall, long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_req && !rst) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= steady || rst ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  task automatic send_pair(input pair_t p);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tdata <= IN_W'({p.mb, p.ma, p.inv, p.rs, p.vby, p.vbx, p.vay, p.vax,
                           p.pby, p.pbx, p.pay, p.pax});
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic drain_and_write(input logic [8:0] e);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= e;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int kind;
    int span;
    kind = $urandom_range(99);
    p.vax = 24'($urandom); p.vay = 24'($urandom); p.vbx = 24'($urandom);
    p.vby = 24'($urandom);
    p.pax = 24'($urandom); p.pay = 24'($urandom);
    p.rs = 16'($urandom);
    p.inv = 17'($urandom_range(131071, 1));
    p.ma = 16'($urandom_range(65535, 1));
    p.mb = 16'($urandom_range(65535, 1));
    if (kind < 75) begin
      // overlapping pair, small velocities most of the time
      span = int'(p.rs) / 2 + 1;
      p.pbx = 24'(int'(p.pax) + int'($urandom_range(2 * span)) - span);
      p.pby = 24'(int'(p.pay) + int'($urandom_range(2 * span)) - span);
      if (kind < 55) begin
        p.vax = 24'(int'($urandom_range(131072)) - 65536);
        p.vay = 24'(int'($urandom_range(131072)) - 65536);
        p.vbx = 24'(int'($urandom_range(131072)) - 65536);
        p.vby = 24'(int'($urandom_range(131072)) - 65536);
        p.ma = 16'($urandom_range(2048, 1));
        p.mb = 16'($urandom_range(2048, 1));
        p.inv = 17'($urandom_range(2048, 1));
      end
    end else begin
      p.pbx = 24'($urandom);
      p.pby = 24'($urandom);
      if (kind > 95) begin
        p.inv = 17'($urandom_range(1, 0));
        p.ma = 16'($urandom_range(1, 0));
        p.mb = 16'($urandom_range(1, 0));
      end
    end
    return p;
  endfunction

  function automatic pair_t make_pair(input int pax, pay, pbx, pby, vax, vay, vbx, vby,
                                      input int rs, inv, ma, mb);
    pair_t p;
    p = '{24'(pax), 24'(pay), 24'(pbx), 24'(pby), 24'(vax), 24'(vay), 24'(vbx), 24'(vby),
          16'(rs), 17'(inv), 16'(ma), 16'(mb)};
    return p;
  endfunction

  initial begin
    pair_t directed[$];
    logic [8:0] settings[5];
    int phase, k;
    settings = '{9'd0, 9'd511, 9'd128, 9'd300, 9'd256};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // head-on overlap, exact touch, just apart, zero distance, rs zero, zero masses
    directed = {directed, make_pair(0, 0, 256, 0, 512, 0, -512, 0, 512, 256, 256, 256)};
    directed = {directed, make_pair(256, 0, 0, 0, -256, 0, 256, 0, 256, 512, 256, 256)};
    directed = {directed, make_pair(257, 0, 0, 0, -256, 0, 256, 0, 256, 512, 256, 256)};
    directed = {directed, make_pair(100, 100, 100, 100, 5, 5, -5, -5, 300, 256, 256, 256)};
    directed = {directed, make_pair(0, 0, 0, 1, 0, 0, 0, -9, 0, 256, 256, 256)};
    directed = {directed, make_pair(0, 0, 10, 0, 10, 0, -10, 0, 100, 0, 0, 0)};
    directed = {directed, make_pair(0, 0, 10, 0, 8388607, 8388607, -8388608, -8388608,
                                    65535, 1, 1, 1)};
    directed = {directed, make_pair(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                                    -8388608, -8388608, 65535, 131071, 65535, 65535)};
    directed = {directed, make_pair(0, 0, 1, 1, -1, 1, 1, -1, 65535, 1, 1, 1)};
    directed = {directed, make_pair(0, 0, 30, 40, 1, 1, -1, -1, 50, 1, 1, 65535)};
    directed = {directed, make_pair(0, 0, 30, 40, -3, -4, 3, 4, 50, 131071, 65535, 1)};
    directed = {directed, make_pair(-1, -1, 0, 0, 8388607, 8388607, -8388608, -8388608,
                                    65535, 1, 1, 1)};
    directed = {directed, make_pair(0, 0, -200, 0, -8388608, 0, 8388607, 0, 65535, 1, 1, 1)};
    steady = 1'b1;
    foreach (directed[k]) send_pair(directed[k]);
    steady = 1'b0;

    for (phase = 0; phase < 5; phase++) begin
      drain_and_write(phase == 4 ? 9'($urandom_range(511)) : settings[phase]);
      foreach (directed[k]) if (k < 3) send_pair(directed[k]);
      if (phase == 1) begin
        hold_req = 1'b1;
        steady = 1'b1;
      end
      for (k = 0; k < 320; k++) begin
        if (phase == 2) steady = k < 150;
        send_pair(random_pair());
      end
      steady = 1'b0;
    end
    drain_and_write(RESTI_RESET);
    for (k = 0; k < 40; k++) send_pair(random_pair());

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d circle pairs over six restitution settings (0, 1/2, 1, 1.17, max, random)",
             pairs_sent);
    $display("results with impulse applied: %0d, with saturated velocity: %0d",
             hit_count, clip_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
